### hw/rtl/ffba_pkg.sv
package ffba_pkg;

   // Field widths fixed by the interface
   localparam int ADDR_W = 16;
   localparam int LEN_W  = 17;

   // Operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_DONE     = 2'd0;
   localparam logic [1:0] STAT_NO_FIT   = 2'd1;
   localparam logic [1:0] STAT_BAD_ADDR = 2'd2;

   // Sequencer states, also broadcast to the cells as the current phase
   localparam logic [3:0] ST_INIT    = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_SEARCH  = 4'd2;
   localparam logic [3:0] ST_ALLOC   = 4'd3;
   localparam logic [3:0] ST_MARK    = 4'd4;
   localparam logic [3:0] ST_MERGE_N = 4'd5;
   localparam logic [3:0] ST_MERGE_P = 4'd6;
   localparam logic [3:0] ST_SUM     = 4'd7;
   localparam logic [3:0] ST_OUT     = 4'd8;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] request_bytes;
      logic [2:0]  align_log2;
      logic [15:0] block_address;
   } ffba_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] address;
      logic [16:0] largest_free;
      logic [16:0] total_free;
   } ffba_rsp_type;

   // One block of the heap, held by one cell
   typedef struct packed {
      logic              vld;
      logic              used;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  len;
   } ffba_entry_type;

   // Running free-space figures rippling down the chain
   typedef struct packed {
      logic [LEN_W-1:0]  largest;
      logic [LEN_W-1:0]  total;
      logic [ADDR_W-1:0] address;
   } ffba_acc_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic [3:0]        phase;
      logic              alloc_op;
      logic [LEN_W-1:0]  size;
      logic [ADDR_W-1:0] addr;
      logic              found;
      logic              split;
      logic              merge;
      ffba_entry_type    init_ent;
   } ffba_cmd_type;

   // Status from each cell back to the sequencer
   typedef struct packed {
      logic hit;
      logic stop;
      logic split;
      logic nfree;
      logic pfree;
   } ffba_flag_type;

endpackage

### hw/rtl/ffba_cell.sv
module ffba_cell
   import ffba_pkg::*;
#(
   parameter int OverheadBytes = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           head,
   input  ffba_cmd_type   cmd,
   input  ffba_entry_type left_ent,
   input  logic           left_tok,
   input  ffba_acc_type   left_acc,
   input  ffba_entry_type right_ent,
   input  logic           right_tok,
   output ffba_entry_type ent,
   output logic           tok,
   output ffba_acc_type   acc,
   output ffba_flag_type  flag
);

   localparam logic [LEN_W-1:0] OV = LEN_W'(OverheadBytes);

   ffba_entry_type ent_ff, ent_in;
   logic           tok_ff, tok_in;
   logic           pre_ff, pre_in;
   ffba_acc_type   acc_ff, acc_in;

   logic             after;
   logic             is_free;
   logic [LEN_W-1:0] rest;

   assign after   = !pre_ff && !tok_ff;
   assign is_free = ent_ff.vld && !ent_ff.used;
   assign rest    = ent_ff.len - cmd.size;

   // Report local match and neighbor status at the token
   always_comb begin
      flag.hit   = tok_ff && (cmd.alloc_op ? (is_free && ent_ff.len >= cmd.size)
                                           : (ent_ff.vld && ent_ff.used
                                              && ent_ff.start == cmd.addr));
      flag.stop  = tok_ff && !ent_ff.vld;
      flag.split = tok_ff && (rest > OV);
      flag.nfree = tok_ff && right_ent.vld && !right_ent.used;
      flag.pfree = tok_ff && left_ent.vld && !left_ent.used;
   end

   // Update the held block for the current phase
   always_comb begin
      ent_in = ent_ff;
      tok_in = tok_ff;
      pre_in = pre_ff;
      case (cmd.phase)
         ST_INIT: begin
            ent_in = head ? cmd.init_ent : '0;
            tok_in = head;
            pre_in = 1'b0;
         end
         ST_IDLE: begin
            tok_in = head;
            pre_in = 1'b0;
         end
         ST_SEARCH: begin
            if (!cmd.found) begin
               tok_in = left_tok;
               pre_in = pre_ff | tok_ff;
            end
         end
         ST_ALLOC: begin
            if (tok_ff) begin
               ent_in.used = 1'b1;
               if (cmd.split) begin
                  ent_in.len = cmd.size;
               end
            end else if (cmd.split && left_tok) begin
               ent_in.vld   = 1'b1;
               ent_in.used  = 1'b0;
               ent_in.start = left_ent.start + ADDR_W'(cmd.size) + ADDR_W'(OV);
               ent_in.len   = left_ent.len - cmd.size - OV;
            end else if (cmd.split && after) begin
               ent_in = left_ent;
            end
         end
         ST_MARK: begin
            if (tok_ff) begin
               ent_in.used = 1'b0;
            end
         end
         ST_MERGE_N: begin
            if (cmd.merge) begin
               if (tok_ff) begin
                  ent_in.len = ent_ff.len + OV + right_ent.len;
               end else if (after) begin
                  ent_in = right_ent;
               end
            end
         end
         ST_MERGE_P: begin
            if (cmd.merge) begin
               if (right_tok) begin
                  ent_in.len = ent_ff.len + OV + right_ent.len;
               end else if (tok_ff || after) begin
                  ent_in = right_ent;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Ripple free-space figures and the token's address down the chain
   always_comb begin
      acc_in.largest = (is_free && ent_ff.len > left_acc.largest) ? ent_ff.len
                                                                  : left_acc.largest;
      acc_in.total   = left_acc.total + (is_free ? ent_ff.len : '0);
      acc_in.address = left_acc.address | ((tok_ff && ent_ff.vld) ? ent_ff.start : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
         pre_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         pre_ff <= pre_in;
      end
      ent_ff <= ent_in;
      acc_ff <= acc_in;
   end

   assign ent = ent_ff;
   assign tok = tok_ff;
   assign acc = acc_ff;

endmodule

### hw/rtl/first_fit_block_allocator.sv
// First-fit heap allocator with coalescing. The heap's blocks sit in address order in a
// chain of MAX_BLOCKS cells, one block per cell, the valid ones packed at the front. An
// allocate walks a token down the chain one cell per cycle to the first free block that
// fits and splits it in place by shifting the later cells one place; a free walks the
// token to the matching used block and merges it with free neighbors by shifting cells
// back. Free-space totals then ripple down the chain. A query is the shortest
// transaction and an allocate or free near the end of the chain the longest, the
// length being set by the token walk and the ripple of the totals; the result is held
// until taken and the next request is taken after that. A heap_size write
// re-initializes the table.
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 12,
   parameter int GUARD_BYTES  = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ffba_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ffba_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [16:0]  csr_data
);

   localparam int               CW       = $clog2(MAX_BLOCKS + 1);
   localparam logic [LEN_W-1:0] OVERHEAD = LEN_W'(HEADER_BYTES + GUARD_BYTES);
   localparam logic [16:0]      HEAP_MAX = 17'd65536;

   logic [3:0]       state_ff, state_in;
   logic [16:0]      heap_ff, heap_in;
   logic [1:0]       op_ff, op_in;
   logic [LEN_W-1:0] size_ff, size_in;
   logic [15:0]      addr_ff, addr_in;
   logic [1:0]       status_ff, status_in;
   logic [CW-1:0]    count_ff, count_in;
   ffba_rsp_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   ffba_cmd_type   cmd;
   ffba_entry_type ent_q  [MAX_BLOCKS];
   ffba_acc_type   acc_q  [MAX_BLOCKS];
   ffba_flag_type  flag_q [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] tok_vec, hit_vec, stop_vec, split_vec, nfree_vec, pfree_vec;

   logic             found, miss;
   logic [16:0]      heap_clamp;
   logic [2:0]       align_eff;
   logic [LEN_W-1:0] req_eff, align_mask;
   logic             req_take, csr_take;

   // Build the chain of cells
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      ffba_entry_type left_ent, right_ent;
      logic           left_tok, right_tok;
      ffba_acc_type   left_acc;
      if (i == 0) begin : g_first
         assign left_ent = '0;
         assign left_tok = 1'b0;
         assign left_acc = '0;
      end else begin : g_mid
         assign left_ent = ent_q[i-1];
         assign left_tok = tok_vec[i-1];
         assign left_acc = acc_q[i-1];
      end
      if (i == MAX_BLOCKS - 1) begin : g_last
         assign right_ent = '0;
         assign right_tok = 1'b0;
      end else begin : g_body
         assign right_ent = ent_q[i+1];
         assign right_tok = tok_vec[i+1];
      end
      ffba_cell #(
         .OverheadBytes(HEADER_BYTES + GUARD_BYTES)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .head     (i == 0),
         .cmd      (cmd),
         .left_ent (left_ent),
         .left_tok (left_tok),
         .left_acc (left_acc),
         .right_ent(right_ent),
         .right_tok(right_tok),
         .ent      (ent_q[i]),
         .tok      (tok_vec[i]),
         .acc      (acc_q[i]),
         .flag     (flag_q[i])
      );
      assign hit_vec[i]   = flag_q[i].hit;
      assign stop_vec[i]  = flag_q[i].stop;
      assign split_vec[i] = flag_q[i].split;
      assign nfree_vec[i] = flag_q[i].nfree;
      assign pfree_vec[i] = flag_q[i].pfree;
   end

   assign found = |hit_vec;
   assign miss  = (|stop_vec) || (tok_vec[MAX_BLOCKS-1] && !found);

   // Broadcast the phase and operands to the cells
   always_comb begin
      heap_clamp       = (heap_ff > HEAP_MAX) ? HEAP_MAX : heap_ff;
      cmd.phase        = state_ff;
      cmd.alloc_op     = (op_ff == OP_ALLOC);
      cmd.size         = size_ff;
      cmd.addr         = addr_ff;
      cmd.found        = found;
      cmd.split        = (|split_vec) && !ent_q[MAX_BLOCKS-1].vld;
      cmd.merge        = (state_ff == ST_MERGE_P) ? (|pfree_vec) : (|nfree_vec);
      cmd.init_ent.vld   = 1'b1;
      cmd.init_ent.used  = 1'b0;
      cmd.init_ent.start = ADDR_W'(HEADER_BYTES);
      cmd.init_ent.len   = (heap_clamp > OVERHEAD) ? (heap_clamp - OVERHEAD) : '0;
   end

   // Round the request up to its alignment
   always_comb begin
      align_eff  = (req_data.align_log2 > 3'd6) ? 3'd6 : req_data.align_log2;
      req_eff    = (req_data.request_bytes == 16'd0) ? LEN_W'(1)
                                                     : LEN_W'(req_data.request_bytes);
      align_mask = (LEN_W'(1) << align_eff) - LEN_W'(1);
   end

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;

   // Sequence one transaction through search, update and summing
   always_comb begin
      state_in     = state_ff;
      heap_in      = heap_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      status_in    = status_ff;
      count_in     = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_take) begin
               heap_in  = csr_data;
               state_in = ST_INIT;
            end else if (req_take) begin
               op_in     = (req_data.operation == OP_ALLOC || req_data.operation == OP_FREE)
                           ? req_data.operation : OP_QUERY;
               size_in   = (req_eff + align_mask) & ~align_mask;
               addr_in   = req_data.block_address;
               status_in = STAT_DONE;
               state_in  = (op_in == OP_QUERY) ? ST_SUM : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (found) begin
               state_in = (op_ff == OP_ALLOC) ? ST_ALLOC : ST_MARK;
            end else if (miss) begin
               status_in = (op_ff == OP_ALLOC) ? STAT_NO_FIT : STAT_BAD_ADDR;
               state_in  = ST_SUM;
            end
         end
         ST_ALLOC:   state_in = ST_SUM;
         ST_MARK:    state_in = ST_MERGE_N;
         ST_MERGE_N: state_in = ST_MERGE_P;
         ST_MERGE_P: state_in = ST_SUM;
         ST_SUM: begin
            count_in = count_ff + CW'(1);
            if (count_ff == CW'(MAX_BLOCKS)) begin
               rsp_in.status       = status_ff;
               rsp_in.address      = (op_ff == OP_ALLOC && status_ff == STAT_DONE)
                                     ? acc_q[MAX_BLOCKS-1].address : '0;
               rsp_in.largest_free = acc_q[MAX_BLOCKS-1].largest;
               rsp_in.total_free   = acc_q[MAX_BLOCKS-1].total;
               rsp_valid_in        = 1'b1;
               state_in            = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         heap_ff      <= HEAP_MAX;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_ff      <= heap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      size_ff   <= size_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // Hold off requests outside idle and while a register write is offered, since the write wins
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // At most one cell holds the token
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("token present in more than one cell");

   // The first block always exists once the table is built
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_INIT && !$past(reset)) |-> ent_q[0].vld)
      else $error("first cell lost its block");

   // Largest free block never exceeds the total
   a_free_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.largest_free <= rsp_data.total_free))
      else $error("largest free exceeds total free");

   // An allocate address is only given with a done status
   a_addr_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_DONE) |-> (rsp_data.address == 16'd0))
      else $error("address reported with a failed transaction");

endmodule

### dv/first_fit_block_allocator_test.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_test;
   import ffba_pkg::*;

   localparam int NUM_BLOCKS  = 64;
   localparam int HDR_BYTES   = 12;
   localparam int GRD_BYTES   = 4;
   localparam int NO_LINK     = NUM_BLOCKS;
   localparam int OVERHEAD    = HDR_BYTES + GRD_BYTES;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 2 * NUM_BLOCKS + 20;

   // Predicts allocator results and holds them until the block returns them
   class heap_scoreboard;
      int unsigned heap_bytes;
      int unsigned blk_start [NUM_BLOCKS];
      int unsigned blk_len [NUM_BLOCKS];
      bit blk_used [NUM_BLOCKS];
      int unsigned nxt [NUM_BLOCKS];
      int unsigned prv [NUM_BLOCKS];
      bit spare [NUM_BLOCKS];
      ffba_rsp_type pending_rsp [$];
      int unsigned live_addr [$];
      int errors;

      function new();
         errors = 0;
         heap_bytes = 65536;
         rebuild();
      endfunction

      function void rebuild();
         int unsigned hs;
         hs = (heap_bytes > 65536) ? 65536 : heap_bytes;
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            blk_start[i] = 0;
            blk_len[i] = 0;
            blk_used[i] = 0;
            nxt[i] = NO_LINK;
            prv[i] = NO_LINK;
            spare[i] = (i != 0);
         end
         blk_start[0] = HDR_BYTES;
         blk_len[0] = (hs > OVERHEAD) ? hs - OVERHEAD : 0;
         live_addr.delete();
      endfunction

      function void set_heap(logic [16:0] val);
         heap_bytes = 32'(val);
         rebuild();
      endfunction

      // Merge a block with its free successor, releasing the successor's entry
      function void merge_next(int unsigned b);
         int unsigned n, nn;
         n = nxt[b];
         if (n >= NO_LINK) return;
         nn = nxt[n];
         blk_len[b] = (blk_len[b] + OVERHEAD + blk_len[n]) & 17'h1FFFF;
         nxt[b] = nn;
         if (nn < NO_LINK) prv[nn] = b;
         spare[n] = 1;
         blk_used[n] = 0;
         nxt[n] = NO_LINK;
         prv[n] = NO_LINK;
         blk_start[n] = 0;
         blk_len[n] = 0;
      endfunction

      function logic [1:0] alloc(int unsigned req, int unsigned alog,
                                 output int unsigned addr);
         int unsigned align, size, b, steps, rest, n, nx;
         int s;
         addr = 0;
         if (alog > 6) alog = 6;
         if (req == 0) req = 1;
         align = 1 << alog;
         size = (req + align - 1) & ~(align - 1);
         b = 0;
         steps = 0;
         while (b < NO_LINK && steps < NUM_BLOCKS) begin
            if (!blk_used[b] && blk_len[b] >= size) break;
            b = nxt[b];
            steps++;
         end
         if (b >= NO_LINK || steps >= NUM_BLOCKS) return STAT_NO_FIT;
         blk_used[b] = 1;
         rest = blk_len[b] - size;
         if (rest > OVERHEAD) begin
            s = -1;
            for (int i = 0; i < NUM_BLOCKS; i++)
               if (s < 0 && spare[i]) s = i;
            if (s >= 0) begin
               n = s;
               nx = nxt[b];
               spare[n] = 0;
               blk_used[n] = 0;
               blk_start[n] = (blk_start[b] + size + OVERHEAD) & 16'hFFFF;
               blk_len[n] = rest - OVERHEAD;
               prv[n] = b;
               nxt[n] = nx;
               if (nx < NO_LINK) prv[nx] = n;
               nxt[b] = n;
               blk_len[b] = size;
            end
         end
         addr = blk_start[b] & 16'hFFFF;
         return STAT_DONE;
      endfunction

      function logic [1:0] release_block(int unsigned addr);
         int unsigned b, steps, p;
         b = 0;
         steps = 0;
         while (b < NO_LINK && steps < NUM_BLOCKS) begin
            if (blk_used[b] && blk_start[b] == addr) break;
            b = nxt[b];
            steps++;
         end
         if (b >= NO_LINK || steps >= NUM_BLOCKS) return STAT_BAD_ADDR;
         blk_used[b] = 0;
         if (nxt[b] < NO_LINK && !blk_used[nxt[b]]) merge_next(b);
         p = prv[b];
         if (p < NO_LINK && !blk_used[p]) merge_next(p);
         return STAT_DONE;
      endfunction

      // Note an accepted request transaction and queue its expected response
      function void note_request(ffba_req_type rq);
         ffba_rsp_type rs;
         int unsigned addr, b, steps, largest, total;
         addr = 0;
         rs = '0;
         if (rq.operation == OP_ALLOC) begin
            rs.status = alloc(32'(rq.request_bytes), 32'(rq.align_log2), addr);
            if (rs.status == STAT_DONE) live_addr.push_back(addr);
         end else if (rq.operation == OP_FREE) begin
            rs.status = release_block(32'(rq.block_address));
            if (rs.status == STAT_DONE)
               foreach (live_addr[i])
                  if (live_addr[i] == rq.block_address) begin
                     live_addr.delete(i);
                     break;
                  end
         end else begin
            rs.status = STAT_DONE;
         end
         largest = 0;
         total = 0;
         b = 0;
         steps = 0;
         while (b < NO_LINK && steps < NUM_BLOCKS) begin
            if (!blk_used[b]) begin
               if (blk_len[b] > largest) largest = blk_len[b];
               total += blk_len[b];
            end
            b = nxt[b];
            steps++;
         end
         rs.address = 16'(addr);
         rs.largest_free = 17'(largest);
         rs.total_free = 17'(total);
         pending_rsp.push_back(rs);
      endfunction

      // Compare one response transaction with the oldest expectation
      function void check_response(ffba_rsp_type got);
         ffba_rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %h", got);
            errors++;
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, got.status);
            errors++;
         end
         if (got.address !== exp_rsp.address) begin
            $error("address expected %0d actual %0d", exp_rsp.address, got.address);
            errors++;
         end
         if (got.largest_free !== exp_rsp.largest_free) begin
            $error("largest_free expected %0d actual %0d",
                   exp_rsp.largest_free, got.largest_free);
            errors++;
         end
         if (got.total_free !== exp_rsp.total_free) begin
            $error("total_free expected %0d actual %0d",
                   exp_rsp.total_free, got.total_free);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ffba_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   ffba_rsp_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [16:0]  csr_data;

   heap_scoreboard sb;
   int  cycle_count;
   bit  idle_free;
   bit  hold_rsp;

   first_fit_block_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("first_fit_block_allocator_test: FAIL");
         $finish;
      end
   end

   // Check each accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // Drive response stall: random idling, with a long hold-off when asked
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (idle_free) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 23);
   end

   // Offer one request transaction and wait for acceptance; valid stays up
   // so that the next call can follow back to back
   task automatic send_request(ffba_req_type rq);
      while (!idle_free && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(rq);
   endtask

   // Drop the request and wait until every response is back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write the heap size while the block is idle
   task automatic write_heap(logic [16:0] val);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_heap(val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic ffba_req_type make_req(logic [1:0] op, logic [15:0] bytes,
                                             logic [2:0] alog, logic [15:0] addr);
      ffba_req_type rq;
      rq.operation = op;
      rq.request_bytes = bytes;
      rq.align_log2 = alog;
      rq.block_address = addr;
      return rq;
   endfunction

   // Mostly small allocates and frees of live blocks, plus noise
   function automatic ffba_req_type random_req();
      ffba_req_type rq;
      int unsigned pick;
      rq.operation = 2'($urandom);
      rq.request_bytes = 16'($urandom);
      rq.align_log2 = 3'($urandom);
      rq.block_address = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 45) begin
         rq.operation = OP_ALLOC;
         if ($urandom_range(9) == 0) rq.request_bytes = 16'($urandom);
         else rq.request_bytes = 16'($urandom_range(200));
      end else if (pick < 85) begin
         rq.operation = OP_FREE;
         if (sb.live_addr.size() != 0 && $urandom_range(9) != 0)
            rq.block_address =
               16'(sb.live_addr[$urandom_range(sb.live_addr.size() - 1)]);
      end else if (pick < 95) begin
         rq.operation = OP_QUERY;
      end else begin
         rq.operation = 2'd3;
      end
      return rq;
   endfunction

   initial begin
      logic [16:0] heap_list [6];
      sb = new();
      cycle_count = 0;
      idle_free = 0;
      hold_rsp = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset heap, every operation and the named corner cases
      send_request(make_req(OP_QUERY, 16'd0, 3'd0, 16'd0));
      send_request(make_req(OP_ALLOC, 16'd0, 3'd0, 16'd0));
      send_request(make_req(OP_ALLOC, 16'd1, 3'd7, 16'd0));
      send_request(make_req(OP_ALLOC, 16'd100, 3'd6, 16'd0));
      send_request(make_req(OP_ALLOC, 16'hFFFF, 3'd0, 16'd0));
      send_request(make_req(OP_FREE, 16'd0, 3'd0, 16'd28));
      send_request(make_req(OP_FREE, 16'd0, 3'd0, 16'd28));
      send_request(make_req(OP_FREE, 16'd0, 3'd0, 16'hFFFF));
      send_request(make_req(2'd3, 16'hFFFF, 3'd7, 16'hFFFF));
      send_request(make_req(OP_FREE, 16'd0, 3'd0, 16'd12));
      send_request(make_req(OP_ALLOC, 16'd3, 3'd2, 16'd0));
      send_request(make_req(OP_FREE, 16'd0, 3'd0, 16'd12));
      send_request(make_req(OP_ALLOC, 16'd65520, 3'd0, 16'd0));
      send_request(make_req(OP_FREE, 16'd0, 3'd0, 16'd12));

      // Tiny heaps: below overhead, an oversized heap, then exactly at the minimum
      write_heap(17'd10);
      send_request(make_req(OP_ALLOC, 16'd1, 3'd0, 16'd0));
      write_heap(17'h1FFFF);
      send_request(make_req(OP_QUERY, 16'd0, 3'd0, 16'd0));
      write_heap(17'd64);
      send_request(make_req(OP_ALLOC, 16'd48, 3'd0, 16'd0));
      send_request(make_req(OP_FREE, 16'd0, 3'd0, 16'd12));

      // Fill the table so allocates stop splitting
      write_heap(17'd65536);
      for (int i = 0; i < 70; i++)
         send_request(make_req(OP_ALLOC, 16'd4, 3'd0, 16'd0));

      // Random phases over several heap sizes
      heap_list[0] = 17'd65536;
      heap_list[1] = 17'd64;
      heap_list[2] = 17'd1024;
      heap_list[3] = 17'($urandom_range(64, 65536));
      heap_list[4] = 17'd4096;
      heap_list[5] = 17'h1FFFF;
      for (int ph = 0; ph < 6; ph++) begin
         write_heap(heap_list[ph]);
         idle_free = (ph == 2);
         if (ph == 3) begin
            fork
               begin
                  hold_rsp = 1;
                  repeat (400) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         for (int i = 0; i < 200; i++) send_request(random_req());
      end
      idle_free = 0;

      wait_drain();
      if (sb.errors == 0 && sb.pending_rsp.size() == 0)
         $display("first_fit_block_allocator_test: PASS");
      else
         $display("first_fit_block_allocator_test: FAIL");
      $finish;
   end

endmodule
